// ===== src/local_peak_detector_defines.svh =====
// ----------------------------------------------------------------------------
// local_peak_detector_defines.svh
// Assertion macros shared by the peak detector modules.
// ----------------------------------------------------------------------------
`ifndef LOCAL_PEAK_DETECTOR_DEFINES_SVH
`define LOCAL_PEAK_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Types and constants of the local peak detector.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int MAX_COLUMN_LENGTH_DEF = 4096;
  localparam int MAX_CHANNELS_DEF      = 256;
  localparam int SAMPLE_WIDTH_DEF      = 16;

  localparam int KIND_W     = 2;
  localparam int POSITION_W = 12;
  localparam int CHANNEL_W  = 8;

  localparam logic [KIND_W-1:0] KIND_PEAK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // result queue: two slots per item plus slack for a stalled sink
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [POSITION_W-1:0] position;
    logic [CHANNEL_W-1:0]  channel;
    logic                  last;
  } result_meta_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== src/lpd_ifs.sv =====
// ----------------------------------------------------------------------------
// lpd_ifs
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
interface sample_if #(
  parameter int SAMPLE_WIDTH = lpd_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_in_column;

  modport source (output valid, sample, last_in_column, input ready);
  modport sink   (input valid, sample, last_in_column, output ready);
endinterface

interface result_if #(
  parameter int SAMPLE_WIDTH = lpd_pkg::SAMPLE_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [lpd_pkg::KIND_W-1:0]        kind;
  logic [lpd_pkg::POSITION_W-1:0]    position;
  logic [lpd_pkg::CHANNEL_W-1:0]     channel;
  logic signed [SAMPLE_WIDTH-1:0]    peak_value;
  logic                              last;

  modport source (output valid, kind, position, channel, peak_value, last, input ready);
  modport sink   (input valid, kind, position, channel, peak_value, last, output ready);
endinterface

// ===== src/local_peak_detector.sv =====
// ----------------------------------------------------------------------------
// local_peak_detector
// Streaming local-peak and column-maximum detector, one column at a time.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------------
//  samples   | in  | valid/ready   | sample, last_in_column
//  results   | out | valid/ready   | kind, position, channel, peak_value, last
//  cfg       | in  | cfg_write     | cfg_data -> include_endpoints
//
//  One sample per cycle while the queue has room: each sample is held in the
//  input register, then its up to two results go into a four-entry result queue.
//  Results leave at one per cycle while the sink is ready, set by the single read
//  port of the queue; input stalls only when the queue lacks two free entries.
//  Synchronous reset clears column state, queue pointers and sets
//  include_endpoints to 1; there is no clearing pass.
// ----------------------------------------------------------------------------
module local_peak_detector #(
  parameter int MAX_COLUMN_LENGTH = lpd_pkg::MAX_COLUMN_LENGTH_DEF,
  parameter int MAX_CHANNELS      = lpd_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH      = lpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  sample_if.sink    samples,
  result_if.source  results
);

  localparam int MW = $bits(lpd_pkg::result_meta_t);
  localparam int QW = MW + SAMPLE_WIDTH;

  lpd_pkg::push_t                 push;
  lpd_pkg::result_meta_t          meta0;
  lpd_pkg::result_meta_t          meta1;
  logic signed [SAMPLE_WIDTH-1:0] value0;
  logic signed [SAMPLE_WIDTH-1:0] value1;
  logic                           room;
  logic [QW-1:0]                  head;
  lpd_pkg::result_meta_t          head_meta;

  lpd_core #(
    .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH),
    .MAX_CHANNELS      (MAX_CHANNELS),
    .SAMPLE_WIDTH      (SAMPLE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .room      (room),
    .push      (push),
    .meta0     (meta0),
    .meta1     (meta1),
    .value0    (value0),
    .value1    (value1)
  );

  lpd_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata0 ({meta0, value0}),
    .wdata1 ({meta1, value1}),
    .room   (room),
    .rvalid (results.valid),
    .rready (results.ready),
    .rdata  (head)
  );

  assign head_meta          = head[QW-1:SAMPLE_WIDTH];
  assign results.kind       = head_meta.kind;
  assign results.position   = head_meta.position;
  assign results.channel    = head_meta.channel;
  assign results.last       = head_meta.last;
  assign results.peak_value = head[SAMPLE_WIDTH-1:0];

endmodule

// ===== src/lpd_fifo.sv =====
// ----------------------------------------------------------------------------
// lpd_fifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module lpd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  lpd_pkg::push_t     push,
  input  logic [WIDTH-1:0]   wdata0,
  input  logic [WIDTH-1:0]   wdata1,
  output logic               room,
  output logic               rvalid,
  input  logic               rready,
  output logic [WIDTH-1:0]   rdata
);
  `include "local_peak_detector_defines.svh"

  localparam int AW  = lpd_pkg::QUEUE_AW;
  localparam int CW  = AW + 1;

  logic [WIDTH-1:0] mem [lpd_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    wptr_next;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [AW-1:0]    wptr1;
  logic             pop;

  assign wptr1  = wptr + AW'(1);
  assign pop    = rvalid && rready;
  assign rvalid = (count != '0);
  assign rdata  = mem[rptr];
  // room for a full two-result push regardless of this cycle's read
  assign room   = (count <= CW'(lpd_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    wptr_next  = wptr + AW'(push.first) + AW'(push.second);
    count_next = count + CW'(push.first) + CW'(push.second) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wptr] <= wdata0;
    end
    if (push.second) begin
      mem[wptr1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      count <= count_next;
      if (pop) begin
        rptr <= rptr + AW'(1);
      end
    end
  end

  `LPD_ASSERT_IMP(a_push_has_room, clk, rst, push.first, count <= CW'(lpd_pkg::QUEUE_DEPTH - 2), "result queue overrun")

endmodule

// ===== src/lpd_core.sv =====
// ----------------------------------------------------------------------------
// lpd_core
// Input register, column state and per-sample peak decision.
// ----------------------------------------------------------------------------
module lpd_core #(
  parameter int MAX_COLUMN_LENGTH = lpd_pkg::MAX_COLUMN_LENGTH_DEF,
  parameter int MAX_CHANNELS      = lpd_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH      = lpd_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic                           cfg_data,
  sample_if.sink                         samples,
  input  logic                           room,
  output lpd_pkg::push_t                 push,
  output lpd_pkg::result_meta_t          meta0,
  output lpd_pkg::result_meta_t          meta1,
  output logic signed [SAMPLE_WIDTH-1:0] value0,
  output logic signed [SAMPLE_WIDTH-1:0] value1
);
  `include "local_peak_detector_defines.svh"

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = $clog2(MAX_COLUMN_LENGTH);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [PW-1:0]  POS_LIMIT = PW'(MAX_COLUMN_LENGTH - 1);
  localparam logic [CHW-1:0] COL_LIMIT = CHW'(MAX_CHANNELS - 1);

  // input register
  logic                 stg_valid;
  logic signed [SW-1:0] stg_sample;
  logic                 stg_last;
  logic                 advance;

  // column state
  logic                 include_endpoints;
  logic signed [SW-1:0] previous_sample, previous_sample_next;
  logic                 was_rising, was_rising_next;
  logic [PW-1:0]        sample_position, sample_position_next;
  logic [CHW-1:0]       column_number, column_number_next;
  logic signed [SW-1:0] best_value, best_value_next;
  logic [PW-1:0]        best_position, best_position_next;
  logic                 peak_found, peak_found_next;
  logic                 overlong, overlong_next;

  // decision terms
  logic                 rising;
  logic                 inner_peak;
  logic                 end_peak;
  logic                 fallback;
  logic                 peak_any;
  logic                 max_out;
  logic                 end_col;
  logic signed [SW-1:0] bv_a, bv_b;
  logic [PW-1:0]        bp_a, bp_b, bp_c;
  logic                 pf_a, pf_b, pf_c;
  logic [PW-1:0]        pk_pos;
  logic signed [SW-1:0] pk_val;
  logic [PW-1:0]        pos_m1;
  lpd_pkg::result_meta_t peak_meta, max_meta, err_meta;

  assign advance       = stg_valid && room;
  assign samples.ready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (samples.ready) begin
      stg_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      stg_sample <= samples.sample;
      stg_last   <= samples.last_in_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      include_endpoints <= 1'b1;
    end else if (cfg_write) begin
      include_endpoints <= cfg_data;
    end
  end

  // best-peak chain: inner peak first, then the trailing endpoint, then fallback
  always_comb begin
    pos_m1     = sample_position - PW'(1);
    rising     = stg_sample > previous_sample;
    inner_peak = was_rising && (previous_sample > stg_sample);
    end_peak   = stg_last && include_endpoints && rising;

    bv_a = best_value;
    bp_a = best_position;
    pf_a = peak_found;
    if (inner_peak) begin
      if (!peak_found || previous_sample > best_value) begin
        bv_a = previous_sample;
        bp_a = pos_m1;
      end
      pf_a = 1'b1;
    end

    bv_b = bv_a;
    bp_b = bp_a;
    pf_b = pf_a;
    if (end_peak) begin
      if (!pf_a || stg_sample > bv_a) begin
        bv_b = stg_sample;
        bp_b = sample_position;
      end
      pf_b = 1'b1;
    end

    // no peak seen: best_value still holds the first sample
    fallback = stg_last && include_endpoints && !pf_b;
    bp_c     = fallback ? '0 : bp_b;
    pf_c     = pf_b || fallback;

    peak_any = inner_peak || end_peak || fallback;
    max_out  = stg_last && pf_c;

    if (inner_peak) begin
      pk_pos = pos_m1;
      pk_val = previous_sample;
    end else if (end_peak) begin
      pk_pos = sample_position;
      pk_val = stg_sample;
    end else begin
      pk_pos = '0;
      pk_val = bv_b;
    end
  end

  always_comb begin
    peak_meta.kind     = lpd_pkg::KIND_PEAK;
    peak_meta.position = lpd_pkg::POSITION_W'(pk_pos);
    peak_meta.channel  = lpd_pkg::CHANNEL_W'(column_number);
    peak_meta.last     = !max_out;

    max_meta.kind      = lpd_pkg::KIND_MAX;
    max_meta.position  = lpd_pkg::POSITION_W'(bp_c);
    max_meta.channel   = lpd_pkg::CHANNEL_W'(column_number);
    max_meta.last      = 1'b1;

    err_meta.kind      = lpd_pkg::KIND_ERROR;
    err_meta.position  = '0;
    err_meta.channel   = lpd_pkg::CHANNEL_W'(column_number);
    err_meta.last      = 1'b1;
  end

  always_comb begin
    previous_sample_next = previous_sample;
    was_rising_next      = was_rising;
    sample_position_next = sample_position;
    column_number_next   = column_number;
    best_value_next      = best_value;
    best_position_next   = best_position;
    peak_found_next      = peak_found;
    overlong_next        = overlong;
    push                 = '0;
    meta0                = '0;
    meta1                = '0;
    value0               = '0;
    value1               = '0;
    end_col              = 1'b0;

    if (advance) begin
      if (overlong) begin
        if (stg_last) begin
          push.first = 1'b1;
          meta0      = err_meta;
          end_col    = 1'b1;
        end
      end else if (sample_position == '0) begin
        previous_sample_next = stg_sample;
        best_value_next      = stg_sample;
        best_position_next   = '0;
        peak_found_next      = 1'b0;
        was_rising_next      = include_endpoints;
        if (stg_last) begin
          push.first = 1'b1;
          meta0      = err_meta;
          end_col    = 1'b1;
        end else begin
          sample_position_next = PW'(1);
        end
      end else begin
        best_value_next    = bv_b;
        best_position_next = bp_c;
        peak_found_next    = pf_c;
        if (peak_any) begin
          push.first  = 1'b1;
          meta0       = peak_meta;
          value0      = pk_val;
          push.second = max_out;
          meta1       = max_meta;
          value1      = bv_b;
        end else if (max_out) begin
          push.first = 1'b1;
          meta0      = max_meta;
          value0     = bv_b;
        end
        if (stg_last) begin
          end_col = 1'b1;
        end else begin
          previous_sample_next = stg_sample;
          was_rising_next      = rising;
          if (sample_position >= POS_LIMIT) begin
            overlong_next = 1'b1;
          end else begin
            sample_position_next = sample_position + PW'(1);
          end
        end
      end

      if (end_col) begin
        sample_position_next = '0;
        overlong_next        = 1'b0;
        peak_found_next      = 1'b0;
        was_rising_next      = 1'b0;
        column_number_next   = (column_number == COL_LIMIT) ? '0
                                                            : column_number + CHW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      was_rising      <= 1'b0;
      sample_position <= '0;
      column_number   <= '0;
      best_value      <= '0;
      best_position   <= '0;
      peak_found      <= 1'b0;
      overlong        <= 1'b0;
    end else begin
      previous_sample <= previous_sample_next;
      was_rising      <= was_rising_next;
      sample_position <= sample_position_next;
      column_number   <= column_number_next;
      best_value      <= best_value_next;
      best_position   <= best_position_next;
      peak_found      <= peak_found_next;
      overlong        <= overlong_next;
    end
  end

  `LPD_ASSERT_IMP(a_second_needs_first, clk, rst, push.second, push.first, "second result without first")
  `LPD_ASSERT_IMP(a_second_is_max, clk, rst, push.second, (meta1.kind == lpd_pkg::KIND_MAX) && meta1.last && !meta0.last, "bad second result")
  `LPD_ASSERT_IMP(a_overlong_at_limit, clk, rst, overlong, sample_position == POS_LIMIT, "overlong below length limit")
  `LPD_ASSERT_NXT(a_column_closes, clk, rst, advance && stg_last, (sample_position == '0) && !overlong && !peak_found, "column state not cleared")

endmodule

// ===== bench/local_peak_detector_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// local_peak_detector_tb
// Self-checking bench for the streaming local-peak detector. A driver sends
// columns of samples from a backlog queue. A monitor compares each result
// transfer with a bit-true prediction of peaks, column maxima and length
// errors. Random gaps on both sides, endpoint setting changed between phases.
// ----------------------------------------------------------------------------
module local_peak_detector_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int SW           = lpd_pkg::SAMPLE_WIDTH_DEF;
  localparam int MAX_LEN      = lpd_pkg::MAX_COLUMN_LENGTH_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 40;
  localparam int RAND_ITEMS   = 1400;
  localparam int RAND_PHASES  = 8;

  typedef struct {
    logic signed [SW-1:0] smp;
    logic                 last_flag;
  } sample_item_t;

  typedef struct {
    logic [lpd_pkg::KIND_W-1:0]     kind;
    logic [lpd_pkg::POSITION_W-1:0] position;
    logic [lpd_pkg::CHANNEL_W-1:0]  channel;
    logic signed [SW-1:0]           peak_value;
    logic                           last;
  } peak_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic cfg_data;

  sample_if #(.SAMPLE_WIDTH(SW)) smp_ch();
  result_if #(.SAMPLE_WIDTH(SW)) res_ch();

  local_peak_detector DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .samples   (smp_ch),
    .results   (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  sample_item_t sample_backlog[$];
  peak_result_t expected_peaks[$];

  // predictor state
  bit                             ep_setting  = 1'b1;
  logic signed [SW-1:0]           prev_smp    = '0;
  logic signed [SW-1:0]           best_val    = '0;
  logic                           rising_prev = 1'b0;
  logic                           found       = 1'b0;
  logic                           long_column = 1'b0;
  int                             smp_pos     = 0;
  int                             best_pos    = 0;
  logic [lpd_pkg::CHANNEL_W-1:0]  column_no   = '0;

  // run statistics
  int samples_sent;
  int columns_closed;
  int channel_wraps;
  int ep_writes;
  int peaks_seen;
  int maxima_seen;
  int errors_seen;
  int mismatch_count;
  int stuck_cycles;

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      calm = $urandom_range(300, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void record_peak(int pos, logic signed [SW-1:0] val);
    if (!found || val > best_val) begin
      best_val = val;
      best_pos = pos;
    end
    found = 1'b1;
  endfunction

  function automatic void close_column();
    smp_pos     = 0;
    long_column = 1'b0;
    found       = 1'b0;
    rising_prev = 1'b0;
    columns_closed++;
    if (column_no == lpd_pkg::MAX_CHANNELS_DEF - 1) channel_wraps++;
    column_no = (int'(column_no) + 1 >= lpd_pkg::MAX_CHANNELS_DEF) ? '0
                                                                   : column_no + 1'b1;
  endfunction

  // Works out the results that one accepted sample causes, in order.
  task automatic predict_peaks(input logic signed [SW-1:0] x, input logic end_flag);
    peak_result_t step_res[2];
    int           n;
    logic         rising_now;
    n = 0;
    if (long_column) begin
      if (end_flag) begin
        step_res[n] = '{lpd_pkg::KIND_ERROR, '0, column_no, '0, 1'b0};
        n++;
        close_column();
      end
    end else if (smp_pos == 0) begin
      prev_smp    = x;
      best_val    = x;
      best_pos    = 0;
      found       = 1'b0;
      rising_prev = ep_setting;
      if (end_flag) begin
        step_res[n] = '{lpd_pkg::KIND_ERROR, '0, column_no, '0, 1'b0};
        n++;
        close_column();
      end else begin
        smp_pos = 1;
      end
    end else begin
      rising_now = (x > prev_smp);
      if (rising_prev && prev_smp > x) begin
        step_res[n] = '{lpd_pkg::KIND_PEAK, lpd_pkg::POSITION_W'(smp_pos - 1),
                        column_no, prev_smp, 1'b0};
        n++;
        record_peak(smp_pos - 1, prev_smp);
      end
      if (end_flag) begin
        if (ep_setting && rising_now) begin
          step_res[n] = '{lpd_pkg::KIND_PEAK, lpd_pkg::POSITION_W'(smp_pos),
                          column_no, x, 1'b0};
          n++;
          record_peak(smp_pos, x);
        end
        // no peak at all: first sample stands in for both results
        if (ep_setting && !found) begin
          step_res[n] = '{lpd_pkg::KIND_PEAK, '0, column_no, best_val, 1'b0};
          n++;
          best_pos = 0;
          found    = 1'b1;
        end
        if (found) begin
          step_res[n] = '{lpd_pkg::KIND_MAX, lpd_pkg::POSITION_W'(best_pos),
                          column_no, best_val, 1'b0};
          n++;
        end
        close_column();
      end else begin
        prev_smp    = x;
        rising_prev = rising_now;
        if (smp_pos >= MAX_LEN - 1) long_column = 1'b1;
        else smp_pos++;
      end
    end
    for (int i = 0; i < n; i++) begin
      step_res[i].last = (i == n - 1);
      expected_peaks.push_back(step_res[i]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- driver
  sample_item_t drv_item;
  int           drv_gap;
  int           drv_calm;

  always @(posedge clk) begin
    if (rst) begin
      smp_ch.valid          <= 1'b0;
      smp_ch.sample         <= '0;
      smp_ch.last_in_column <= 1'b0;
      drv_gap  = 0;
      drv_calm = 0;
    end else begin
      if (smp_ch.valid && smp_ch.ready) begin
        predict_peaks(smp_ch.sample, smp_ch.last_in_column);
        samples_sent++;
      end
      if (!smp_ch.valid || smp_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          smp_ch.valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          drv_item = sample_backlog.pop_front();
          smp_ch.sample         <= drv_item.smp;
          smp_ch.last_in_column <= drv_item.last_flag;
          smp_ch.valid          <= 1'b1;
          drv_gap = pick_gap(drv_calm);
        end else begin
          smp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  peak_result_t want;
  int           mon_stall;
  int           mon_calm;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      mon_stall = 0;
      mon_calm  = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        case (res_ch.kind)
          lpd_pkg::KIND_PEAK: peaks_seen++;
          lpd_pkg::KIND_MAX:  maxima_seen++;
          default:            errors_seen++;
        endcase
        if (expected_peaks.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d pos %0d ch %0d val %0d",
                                    res_ch.kind, res_ch.position, res_ch.channel,
                                    res_ch.peak_value));
        end else begin
          want = expected_peaks.pop_front();
          if (res_ch.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", res_ch.kind, want.kind));
          if (res_ch.position !== want.position)
            report_mismatch($sformatf("position %0d, want %0d (ch %0d)",
                                      res_ch.position, want.position, want.channel));
          if (res_ch.channel !== want.channel)
            report_mismatch($sformatf("channel %0d, want %0d", res_ch.channel, want.channel));
          if (res_ch.peak_value !== want.peak_value)
            report_mismatch($sformatf("peak_value %0d, want %0d (ch %0d)",
                                      res_ch.peak_value, want.peak_value, want.channel));
          if (res_ch.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (ch %0d)",
                                      res_ch.last, want.last, want.channel));
        end
      end
      if (mon_stall > 0) begin
        mon_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(99) < 30) mon_stall = pick_gap(mon_calm);
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    do @(negedge clk); while (stuck_cycles < STUCK_LIMIT);
    $display("[%0t] no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  task automatic push_sample(input int v, input bit end_flag);
    sample_item_t it;
    it.smp       = SW'(v);
    it.last_flag = end_flag;
    sample_backlog.push_back(it);
  endtask

  task automatic queue_column(input int len);
    int mode;
    int apex;
    int base;
    int step;
    int v;
    mode = $urandom_range(3);
    apex = $urandom_range(len - 1);
    base = int'($urandom_range(65535)) - 32768;
    step = $urandom_range(3000);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom;
        1: v = int'($urandom_range(4)) - 2;  // many equal neighbors
        2: begin
          case ($urandom_range(3))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = -1;
            default: v = 0;
          endcase
        end
        default: v = (i <= apex) ? base + i * step : base + (2 * apex - i) * step;
      endcase
      push_sample(v, i == len - 1);
    end
  endtask

  // block is idle once all transfers are done; then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || smp_ch.valid || expected_peaks.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_endpoints(input bit v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    ep_setting = v;
    ep_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int queued;
    int len;
    int r;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // endpoints on, as after reset
    push_sample(5, 1);                          // one-sample column
    push_sample(32767, 0);  push_sample(-32768, 1);
    push_sample(-32768, 0); push_sample(32767, 1);
    push_sample(7, 0); push_sample(7, 0); push_sample(7, 1);  // flat: fallback
    push_sample(0, 0); push_sample(100, 0); push_sample(-5, 0);
    push_sample(100, 0); push_sample(3, 1);     // tie, first peak wins
    wait_idle();

    set_endpoints(1'b0);
    push_sample(1, 0); push_sample(9, 0); push_sample(2, 0);
    push_sample(8, 0); push_sample(0, 1);
    push_sample(3, 0); push_sample(1, 1);       // no peak, nothing emitted
    push_sample(-32768, 0); push_sample(-32768, 0); push_sample(32767, 1);
    push_sample(9, 1);
    wait_idle();

    // full-length column, then one that runs past the limit
    set_endpoints(1'b1);
    queue_column(MAX_LEN);
    queue_column(MAX_LEN + $urandom_range(20, 1));
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_endpoints(1'(ph % 2));
      queued = 0;
      while (queued < RAND_ITEMS / RAND_PHASES) begin
        r = $urandom_range(99);
        if (r < 15)      len = 1;
        else if (r < 87) len = $urandom_range(4, 2);
        else if (r < 98) len = $urandom_range(16, 5);
        else             len = $urandom_range(80, 17);
        queue_column(len);
        queued += len;
      end
      // sometimes leave a column open across the setting change
      if ($urandom_range(2) == 0) begin
        len = $urandom_range(3, 1);
        for (int i = 0; i < len; i++) push_sample($urandom, 1'b0);
      end
      wait_idle();
    end

    $display("Covered %0d samples in %0d columns, %0d setting writes, %0d channel wraps.",
             samples_sent, columns_closed, ep_writes, channel_wraps);
    $display("Checked %0d local peaks, %0d column maxima, %0d length errors.",
             peaks_seen, maxima_seen, errors_seen);
    if (mismatch_count == 0 && expected_peaks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
